[rtl/core/mmaf_pkg.sv]
package mmaf_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int CH_OUT_W   = 2;
  localparam int MASK_W     = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CH_OUT_W-1:0] ch_out_t;
  typedef logic [MASK_W-1:0]   mask_t;

  localparam sample_t FILT_MAX = '1;

endpackage

[rtl/core/mmaf_ram.sv]
module mmaf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/mmaf_seq.sv]
module mmaf_seq #(
  parameter int NUM_CHANNELS = 4,
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  mmaf_pkg::sample_t                             in_sample,
  input  logic                                          take,
  output logic                                          s1_valid,
  output logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] s1_ch,
  output mmaf_pkg::sample_t                             s1_sample,
  output mmaf_pkg::sample_t                             old_sample
);
  import mmaf_pkg::*;

  localparam int CH_W   = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W  = $clog2(WINDOW_DEPTH);
  localparam int DEPTH  = NUM_CHANNELS * WINDOW_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [CH_W-1:0]   cur_ch_r;
  logic [CH_W-1:0]   cur_ch_nxt;
  logic [POS_W-1:0]  wpos_r [NUM_CHANNELS];
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  pos_nxt;
  logic              s1_valid_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic [ADDR_W-1:0] s1_addr_r;
  sample_t           s1_sample_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              accept;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  sample_t           ram_wr_data;

  assign in_tready = !clearing_r && (!s1_valid_r || take);
  assign accept    = in_tvalid && in_tready;

  assign cur_pos = wpos_r[cur_ch_r];
  assign rd_addr = ADDR_W'(ADDR_W'(cur_ch_r) * ADDR_W'(WINDOW_DEPTH)) + ADDR_W'(cur_pos);
  assign pos_nxt = (cur_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : POS_W'(cur_pos + 1'b1);
  assign cur_ch_nxt = (cur_ch_r == CH_W'(NUM_CHANNELS - 1)) ? '0 : CH_W'(cur_ch_r + 1'b1);

  // clear sweep after reset, then item writes back the new sample
  assign ram_wr_en   = clearing_r || take;
  assign ram_wr_addr = clearing_r ? clr_addr_r : s1_addr_r;
  assign ram_wr_data = clearing_r ? '0 : s1_sample_r;

  mmaf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (old_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      cur_ch_r   <= '0;
      s1_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wpos_r[i] <= '0;
      end
    end else begin
      if (clearing_r) begin
        clr_addr_r <= ADDR_W'(clr_addr_r + 1'b1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_r       <= 1'b1;
        wpos_r[cur_ch_r] <= pos_nxt;
        cur_ch_r         <= cur_ch_nxt;
      end else if (take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch_r     <= cur_ch_r;
      s1_addr_r   <= rd_addr;
      s1_sample_r <= in_sample;
    end
  end

  assign s1_valid  = s1_valid_r;
  assign s1_ch     = s1_ch_r;
  assign s1_sample = s1_sample_r;

  a_no_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> s1_valid_r)
    else $error("stage taken while empty");

  a_stall_holds_addr: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !take |=> s1_valid_r && $stable(s1_addr_r) && $stable(s1_ch_r))
    else $error("stalled stage lost its item");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_ch_r) < NUM_CHANNELS)
    else $error("channel out of range");

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r && !accept)
    else $error("item taken during clear sweep");

endmodule

[rtl/core/mmaf_acc.sv]
module mmaf_acc #(
  parameter int NUM_CHANNELS = 4,
  parameter int WINDOW_DEPTH = 8,
  parameter int AVG_SHIFT    = 3
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_wen,
  input  mmaf_pkg::mask_t                               cfg_wdata,
  input  logic                                          s1_valid,
  input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] s1_ch,
  input  mmaf_pkg::sample_t                             s1_sample,
  input  mmaf_pkg::sample_t                             old_sample,
  output logic                                          take,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output mmaf_pkg::ch_out_t                             out_channel,
  output mmaf_pkg::sample_t                             out_filtered,
  output logic                                          out_changed,
  output mmaf_pkg::ch_out_t                             out_next_channel
);
  import mmaf_pkg::*;

  localparam int CH_W  = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

  mask_t             mask_r;
  logic [SUM_W-1:0]  sums_r [NUM_CHANNELS];
  sample_t           prev_r [NUM_CHANNELS];
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  shifted;
  sample_t           filt;
  logic              enabled;
  logic              changed;
  logic [CH_W-1:0]   next_ch;
  logic              out_valid_r;
  ch_out_t           out_ch_r;
  sample_t           out_filt_r;
  logic              out_changed_r;
  ch_out_t           out_next_r;

  assign take = s1_valid && (!out_valid_r || out_tready);

  assign sum_nxt = SUM_W'(sums_r[s1_ch] - SUM_W'(old_sample) + SUM_W'(s1_sample));
  assign shifted = sum_nxt >> AVG_SHIFT;
  assign filt    = (shifted > SUM_W'(FILT_MAX)) ? FILT_MAX : SAMPLE_W'(shifted);
  // channels past the mask width never report
  assign enabled = (32'(s1_ch) < MASK_W) && mask_r[CH_OUT_W'(s1_ch)];
  assign changed = enabled && (filt != prev_r[s1_ch]);
  assign next_ch = (s1_ch == CH_W'(NUM_CHANNELS - 1)) ? '0 : CH_W'(s1_ch + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums_r[i] <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        mask_r <= cfg_wdata;
      end
      if (take) begin
        sums_r[s1_ch] <= sum_nxt;
        prev_r[s1_ch] <= filt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch_r      <= CH_OUT_W'(s1_ch);
      out_filt_r    <= filt;
      out_changed_r <= changed;
      out_next_r    <= CH_OUT_W'(next_ch);
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_channel      = out_ch_r;
  assign out_filtered     = out_filt_r;
  assign out_changed      = out_changed_r;
  assign out_next_channel = out_next_r;

  a_next_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_tvalid && (out_next_channel == $past(CH_OUT_W'(next_ch))))
    else $error("next channel mismatch");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_ch_r) &&
      $stable(out_filt_r) && $stable(out_changed_r) && $stable(out_next_r))
    else $error("stalled result changed");

  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> s1_valid)
    else $error("result taken without item");

endmodule

[rtl/core/multichannel_moving_average_filter.sv]
// multichannel boxcar moving average filter
// input channel in_*: one 10-bit sample per item, for the channel currently
//   selected; channels are served round robin starting at channel 0
// result channel out_*: one item per sample with the channel it belonged to,
//   the window average (sum >> AVG_SHIFT, saturated), a change flag for
//   enabled channels and the channel to select next
// cfg_wen / cfg_wdata: per-channel enable mask for change reporting
// path: input stage registers the sample, then output register the result
// throughput: one item per cycle unless stalled; window memory is read at
//   acceptance, written back when taken, so consecutive items never collide
// reset: windows, sums, previous values and positions clear; the window
//   memory is swept to zero, all NUM_CHANNELS * WINDOW_DEPTH entries
//   (32 with the defaults), with in_tready low, config writes still taken
// stall: an output register holds the result while out_tready is low; one
//   more item waits in the input stage, then in_tready drops
module multichannel_moving_average_filter #(
  parameter int NUM_CHANNELS = 4,
  parameter int WINDOW_DEPTH = 8,
  parameter int AVG_SHIFT    = 3
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wen,
  input  mmaf_pkg::mask_t                        cfg_wdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // sample[9:0], zero pad
  input  logic [mmaf_pkg::IN_DATA_W-1:0]         in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // channel[1:0], filtered[11:2], changed[12], next_channel[14:13], zero pad
  output logic [mmaf_pkg::OUT_DATA_W-1:0]        out_tdata
);
  import mmaf_pkg::*;

  localparam int CH_W = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

  logic            take;
  logic            s1_valid;
  logic [CH_W-1:0] s1_ch;
  sample_t         s1_sample;
  sample_t         old_sample;
  ch_out_t         out_channel;
  sample_t         out_filtered;
  logic            out_changed;
  ch_out_t         out_next_channel;

  mmaf_seq #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .take       (take),
    .s1_valid   (s1_valid),
    .s1_ch      (s1_ch),
    .s1_sample  (s1_sample),
    .old_sample (old_sample)
  );

  mmaf_acc #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .AVG_SHIFT    (AVG_SHIFT)
  ) u_acc (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wen          (cfg_wen),
    .cfg_wdata        (cfg_wdata),
    .s1_valid         (s1_valid),
    .s1_ch            (s1_ch),
    .s1_sample        (s1_sample),
    .old_sample       (old_sample),
    .take             (take),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_channel      (out_channel),
    .out_filtered     (out_filtered),
    .out_changed      (out_changed),
    .out_next_channel (out_next_channel)
  );

  assign out_tdata = {
    {(OUT_DATA_W - 2 * CH_OUT_W - SAMPLE_W - 1){1'b0}},
    out_next_channel, out_changed, out_filtered, out_channel
  };

endmodule
